>>> hdl/crb_pkg.sv
// shared types, codes and constants of the clipped rectangle blit engine
// no dependencies; used by every other file of the block

package crb_pkg;

  localparam int MAX_SIDE  = 2048;
  localparam int SIDE_W    = 12;
  localparam int ADDR_W    = 22;
  localparam int PIX_W     = 32;
  localparam int ALPHA_LSB = 24;
  localparam int CLIP_W    = 16;   // signed working width of the clipping math
  localparam int PROD_W    = 2 * SIDE_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_BEAT  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    OP_FILL    = 2'd0,
    OP_COPY    = 2'd1,
    OP_COMBINE = 2'd2,
    OP_MASK    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_START     = 2'd0,
    KIND_PIXEL     = 2'd1,
    KIND_IDLE_BEAT = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_COLS   = 2'd0,
    CFG_DEST_ROWS   = 2'd1,
    CFG_SOURCE_COLS = 2'd2,
    CFG_SOURCE_ROWS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    func_e                     func;
    op_e                       operation;
    logic signed [SIDE_W-1:0]  dest_left;
    logic signed [SIDE_W-1:0]  dest_top;
    logic signed [SIDE_W-1:0]  source_left;
    logic signed [SIDE_W-1:0]  source_top;
    logic [SIDE_W-1:0]         rect_cols;
    logic [SIDE_W-1:0]         rect_rows;
    logic [PIX_W-1:0]          fill_color;
    logic [PIX_W-1:0]          source_pixel;
    logic [PIX_W-1:0]          backdrop_pixel;
  } req_t;

  typedef struct packed {
    kind_e             kind;
    logic              accepted;
    logic [SIDE_W-1:0] clipped_cols;
    logic [SIDE_W-1:0] clipped_rows;
    logic [ADDR_W-1:0] dest_address;
    logic [ADDR_W-1:0] source_address;
    logic [PIX_W-1:0]  out_pixel;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [SIDE_W-1:0] dest_cols;
    logic [SIDE_W-1:0] dest_rows;
    logic [SIDE_W-1:0] source_cols;
    logic [SIDE_W-1:0] source_rows;
  } cfg_t;

  // clipped start geometry handed from the clipper to the raster walker
  typedef struct packed {
    logic              ok;
    logic [SIDE_W-1:0] cols;
    logic [SIDE_W-1:0] rows;
    logic [ADDR_W-1:0] dest_index;
    logic [ADDR_W-1:0] source_index;
  } start_t;

endpackage

>>> hdl/crb_ifs.sv
// valid/ready channel interfaces of the blit engine: request, result, config
// depends on crb_pkg for field widths

interface crb_req_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [1:0]                          operation;
  logic signed [crb_pkg::SIDE_W-1:0]   dest_left;
  logic signed [crb_pkg::SIDE_W-1:0]   dest_top;
  logic signed [crb_pkg::SIDE_W-1:0]   source_left;
  logic signed [crb_pkg::SIDE_W-1:0]   source_top;
  logic [crb_pkg::SIDE_W-1:0]          rect_cols;
  logic [crb_pkg::SIDE_W-1:0]          rect_rows;
  logic [crb_pkg::PIX_W-1:0]           fill_color;
  logic [crb_pkg::PIX_W-1:0]           source_pixel;
  logic [crb_pkg::PIX_W-1:0]           backdrop_pixel;

  modport source (
    output valid, func, operation, dest_left, dest_top, source_left, source_top,
           rect_cols, rect_rows, fill_color, source_pixel, backdrop_pixel,
    input  ready
  );
  modport sink (
    input  valid, func, operation, dest_left, dest_top, source_left, source_top,
           rect_cols, rect_rows, fill_color, source_pixel, backdrop_pixel,
    output ready
  );
endinterface

interface crb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic                         accepted;
  logic [crb_pkg::SIDE_W-1:0]   clipped_cols;
  logic [crb_pkg::SIDE_W-1:0]   clipped_rows;
  logic [crb_pkg::ADDR_W-1:0]   dest_address;
  logic [crb_pkg::ADDR_W-1:0]   source_address;
  logic [crb_pkg::PIX_W-1:0]    out_pixel;
  logic                         last;

  modport source (
    output valid, kind, accepted, clipped_cols, clipped_rows, dest_address,
           source_address, out_pixel, last,
    input  ready
  );
  modport sink (
    input  valid, kind, accepted, clipped_cols, clipped_rows, dest_address,
           source_address, out_pixel, last,
    output ready
  );
endinterface

interface crb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [crb_pkg::CFG_IDX_W-1:0]   index;
  logic [crb_pkg::SIDE_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/clipped_rect_blit_engine_unit.sv
// top level of the clipped rectangle blit engine
// depends on crb_pkg, crb_ifs, crb_cfg, crb_clip and crb_raster

// usage:
// - cfg channel writes the destination and source bitmap sizes (index 0..3:
//   dest cols, dest rows, source cols, source rows); values above 2048 are held
//   at 2048; always ready; write only while no request is in flight
// - req channel carries start requests (func 0) and pixel beats (func 1)
// - rsp channel returns exactly one response per request, in order:
//   a start report, a pixel write with addresses and last flag, or an
//   idle-beat marker when no operation is running
// - a start request clips the rectangle and computes the first pixel indices
//   (one 12x12 multiply per bitmap); a beat steps the raster addresses
// - path: a request goes through the input register, then the result register
// - throughput: one request per cycle while rsp is not stalled; the raster
//   state steps between input register and result register
// - rsp stall: the result register holds, the input register takes one more
//   request only if it is empty, then req ready drops until the stall clears
// - reset: sizes return to 128, engine idle, both pipeline registers empty

module clipped_rect_blit_engine_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  crb_req_if.sink      req,
  crb_rsp_if.source    rsp,
  crb_cfg_if.sink      cfg
);
  import crb_pkg::*;

  req_t   req_in;
  req_t   req_q;
  logic   req_valid_q;
  rsp_t   rsp_d, rsp_q;
  logic   rsp_valid_q;
  logic   advance;
  cfg_t   cfg_now;
  start_t start;

  // configuration registers
  assign cfg.ready = 1'b1;

  crb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg.valid),
    .index_i (cfg.index),
    .data_i  (cfg.data),
    .cfg_o   (cfg_now)
  );

  // gather the request fields
  always_comb begin
    req_in.func           = func_e'(req.func);
    req_in.operation      = op_e'(req.operation);
    req_in.dest_left      = req.dest_left;
    req_in.dest_top       = req.dest_top;
    req_in.source_left    = req.source_left;
    req_in.source_top     = req.source_top;
    req_in.rect_cols      = req.rect_cols;
    req_in.rect_rows      = req.rect_rows;
    req_in.fill_color     = req.fill_color;
    req_in.source_pixel   = req.source_pixel;
    req_in.backdrop_pixel = req.backdrop_pixel;
  end

  // move the held request into the result register when it is free
  assign advance   = req_valid_q && (!rsp_valid_q || rsp.ready);
  assign req.ready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req.ready) begin
      req_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      req_q <= req_in;
    end
  end

  // start geometry and raster stepping between the two registers
  crb_clip u_clip (
    .req_i   (req_q),
    .cfg_i   (cfg_now),
    .start_o (start)
  );

  crb_raster u_raster (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .req_i   (req_q),
    .start_i (start),
    .cfg_i   (cfg_now),
    .rsp_o   (rsp_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp.valid          = rsp_valid_q;
  assign rsp.kind           = rsp_q.kind;
  assign rsp.accepted       = rsp_q.accepted;
  assign rsp.clipped_cols   = rsp_q.clipped_cols;
  assign rsp.clipped_rows   = rsp_q.clipped_rows;
  assign rsp.dest_address   = rsp_q.dest_address;
  assign rsp.source_address = rsp_q.source_address;
  assign rsp.out_pixel      = rsp_q.out_pixel;
  assign rsp.last           = rsp_q.last;

`ifndef SYNTHESIS
  a_advance_fills_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> rsp_valid_q)
    else $error("request advanced but no response registered");

  a_accepted_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.kind == KIND_START) && rsp_q.accepted
      |-> (rsp_q.clipped_cols != '0) && (rsp_q.clipped_rows != '0))
    else $error("accepted start with empty clipped size");

  a_rejected_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.kind == KIND_START) && !rsp_q.accepted
      |-> (rsp_q.clipped_cols == '0) && (rsp_q.clipped_rows == '0))
    else $error("rejected start reports a nonzero size");
`endif

endmodule

>>> hdl/crb_cfg.sv
// bitmap size registers with clamping to the largest side
// depends on crb_pkg

module crb_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [crb_pkg::CFG_IDX_W-1:0] index_i,
  input  logic [crb_pkg::SIDE_W-1:0]    data_i,
  output crb_pkg::cfg_t    cfg_o
);
  import crb_pkg::*;

  localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(128);

  cfg_t              cfg_q, cfg_d;
  logic [SIDE_W-1:0] value;

  always_comb begin
    value = (data_i > SIDE_MAX) ? SIDE_MAX : data_i;
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(index_i))
        CFG_DEST_COLS:   cfg_d.dest_cols   = value;
        CFG_DEST_ROWS:   cfg_d.dest_rows   = value;
        CFG_SOURCE_COLS: cfg_d.source_cols = value;
        CFG_SOURCE_ROWS: cfg_d.source_rows = value;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{dest_cols: SIDE_RESET, dest_rows: SIDE_RESET,
                 source_cols: SIDE_RESET, source_rows: SIDE_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/crb_clip.sv
// start geometry: clip against source then destination, first pixel indices
// depends on crb_pkg

module crb_clip (
  input  crb_pkg::req_t   req_i,
  input  crb_pkg::cfg_t   cfg_i,
  output crb_pkg::start_t start_o
);
  import crb_pkg::*;

  typedef struct packed {
    logic                     ok;
    logic signed [CLIP_W-1:0] p;
    logic signed [CLIP_W-1:0] q;
    logic signed [CLIP_W-1:0] w;
  } axis_t;

  // one axis: p is the origin being clipped, q the partner origin
  function automatic axis_t clip_axis(input logic signed [CLIP_W-1:0] lim,
                                      input logic signed [CLIP_W-1:0] p,
                                      input logic signed [CLIP_W-1:0] q,
                                      input logic signed [CLIP_W-1:0] w);
    axis_t r;
    r.ok = !(((p + w) < 0) || (p >= lim));
    r.p  = p;
    r.q  = q;
    r.w  = w;
    if (p < 0) begin
      r.w = w + p;
      r.q = q - p;
      r.p = '0;
    end
    if ((r.p + r.w) > lim) begin
      r.w = lim - r.p;
    end
    return r;
  endfunction

  function automatic logic signed [CLIP_W-1:0] sext(input logic [SIDE_W-1:0] v);
    return {{(CLIP_W-SIDE_W){v[SIDE_W-1]}}, v};
  endfunction

  function automatic logic signed [CLIP_W-1:0] zext(input logic [SIDE_W-1:0] v);
    return {{(CLIP_W-SIDE_W){1'b0}}, v};
  endfunction

  logic                     is_fill;
  axis_t                    src_x, src_y, dst_x, dst_y;
  logic signed [CLIP_W-1:0] dp_x, dp_y, dq_x, dq_y, dw_x, dw_y;
  logic [PROD_W-1:0]        dest_prod, source_prod;

  always_comb begin
    is_fill = (req_i.operation == OP_FILL);

    src_x = clip_axis(zext(cfg_i.source_cols), sext(req_i.source_left),
                      sext(req_i.dest_left), zext(req_i.rect_cols));
    src_y = clip_axis(zext(cfg_i.source_rows), sext(req_i.source_top),
                      sext(req_i.dest_top), zext(req_i.rect_rows));

    // fill skips the source clip and has no source origin
    dp_x = is_fill ? sext(req_i.dest_left) : src_x.q;
    dp_y = is_fill ? sext(req_i.dest_top)  : src_y.q;
    dq_x = is_fill ? '0 : src_x.p;
    dq_y = is_fill ? '0 : src_y.p;
    dw_x = is_fill ? zext(req_i.rect_cols) : src_x.w;
    dw_y = is_fill ? zext(req_i.rect_rows) : src_y.w;

    dst_x = clip_axis(zext(cfg_i.dest_cols), dp_x, dq_x, dw_x);
    dst_y = clip_axis(zext(cfg_i.dest_rows), dp_y, dq_y, dw_y);

    start_o.ok = (is_fill || (src_x.ok && src_y.ok)) && dst_x.ok && dst_y.ok
                 && (dst_x.w > 0) && (dst_y.w > 0);
    start_o.cols = dst_x.w[SIDE_W-1:0];
    start_o.rows = dst_y.w[SIDE_W-1:0];

    // clipped origins are non-negative and below 4096 when ok
    dest_prod   = PROD_W'(dst_y.p[SIDE_W-1:0]) * PROD_W'(cfg_i.dest_cols);
    source_prod = PROD_W'(dst_y.q[SIDE_W-1:0]) * PROD_W'(cfg_i.source_cols);
    start_o.dest_index = ADDR_W'(dest_prod + PROD_W'(dst_x.p[SIDE_W-1:0]));
    start_o.source_index = is_fill ? '0
                         : ADDR_W'(source_prod + PROD_W'(dst_x.q[SIDE_W-1:0]));
  end

endmodule

>>> hdl/crb_raster.sv
// raster walker: operation state, pixel combine and address stepping
// depends on crb_pkg; takes the clipped start geometry from crb_clip

module crb_raster (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  crb_pkg::req_t   req_i,
  input  crb_pkg::start_t start_i,
  input  crb_pkg::cfg_t   cfg_i,
  output crb_pkg::rsp_t   rsp_o
);
  import crb_pkg::*;

  logic              active_q, active_d;
  op_e               op_q, op_d;
  logic [PIX_W-1:0]  color_q, color_d;
  logic [SIDE_W-1:0] span_cols_q, span_cols_d, span_rows_q, span_rows_d;
  logic [SIDE_W-1:0] col_q, col_d, row_q, row_d;
  logic [ADDR_W-1:0] dest_q, dest_d, src_q, src_d;

  logic [SIDE_W:0]   col_inc, row_inc;
  logic              wrap, last;
  logic [PIX_W-1:0]  pix;
  logic [PIX_W-1:0]  src_pix, bg_pix;

  always_comb begin
    src_pix = req_i.source_pixel;
    bg_pix  = req_i.backdrop_pixel;
    case (op_q)
      OP_FILL:    pix = color_q;
      OP_COPY:    pix = src_pix;
      OP_COMBINE: pix = (src_pix[PIX_W-1:ALPHA_LSB] != '0) ? src_pix : bg_pix;
      OP_MASK:    pix = {bg_pix[PIX_W-1:ALPHA_LSB], src_pix[ALPHA_LSB-1:0]};
      default:    pix = src_pix;
    endcase

    col_inc = {1'b0, col_q} + 1'b1;
    row_inc = {1'b0, row_q} + 1'b1;
    wrap    = (col_inc >= {1'b0, span_cols_q});
    last    = wrap && (row_inc >= {1'b0, span_rows_q});

    active_d    = active_q;
    op_d        = op_q;
    color_d     = color_q;
    span_cols_d = span_cols_q;
    span_rows_d = span_rows_q;
    col_d       = col_q;
    row_d       = row_q;
    dest_d      = dest_q;
    src_d       = src_q;

    rsp_o      = '0;
    rsp_o.kind = KIND_IDLE_BEAT;

    if (req_i.func == FUNC_START) begin
      rsp_o.kind = KIND_START;
      active_d   = start_i.ok;
      if (start_i.ok) begin
        rsp_o.accepted     = 1'b1;
        rsp_o.clipped_cols = start_i.cols;
        rsp_o.clipped_rows = start_i.rows;
        op_d        = req_i.operation;
        color_d     = req_i.fill_color;
        span_cols_d = start_i.cols;
        span_rows_d = start_i.rows;
        col_d       = '0;
        row_d       = '0;
        dest_d      = start_i.dest_index;
        src_d       = start_i.source_index;
      end
    end else if (active_q) begin
      rsp_o.kind           = KIND_PIXEL;
      rsp_o.dest_address   = dest_q;
      rsp_o.source_address = (op_q == OP_FILL) ? '0 : src_q;
      rsp_o.out_pixel      = pix;
      rsp_o.last           = last;

      // row wrap skips the stride remainder on the destination, and on the source unless filling
      col_d  = wrap ? '0 : col_inc[SIDE_W-1:0];
      row_d  = wrap ? row_inc[SIDE_W-1:0] : row_q;
      dest_d = dest_q + ADDR_W'(1)
             + (wrap ? (ADDR_W'(cfg_i.dest_cols) - ADDR_W'(span_cols_q)) : '0);
      if (op_q != OP_FILL) begin
        src_d = src_q + ADDR_W'(1)
              + (wrap ? (ADDR_W'(cfg_i.source_cols) - ADDR_W'(span_cols_q)) : '0);
      end
      if (last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      op_q        <= OP_FILL;
      span_cols_q <= '0;
      span_rows_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
      dest_q      <= '0;
      src_q       <= '0;
    end else if (step_i) begin
      active_q    <= active_d;
      op_q        <= op_d;
      span_cols_q <= span_cols_d;
      span_rows_q <= span_rows_d;
      col_q       <= col_d;
      row_q       <= row_d;
      dest_q      <= dest_d;
      src_q       <= src_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      color_q <= color_d;
    end
  end

`ifndef SYNTHESIS
  a_counts_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (col_q < span_cols_q) && (row_q < span_rows_q))
    else $error("raster counters outside the clipped span");

  a_last_ends_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (rsp_o.kind == KIND_PIXEL) && rsp_o.last |=> !active_q)
    else $error("engine still active after last pixel");
`endif

endmodule

>>> bench/tb.sv
// self-checking bench for clipped_rect_blit_engine_unit: directed table, then random phases
// drives request and config channels, checks responses against a predictor or hand-typed rows
// depends on crb_pkg and crb_ifs from the rtl

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORK_TARGET = 950;

  logic clk_i = 1'b0;
  logic rst_ni;

  crb_req_if req_if ();
  crb_rsp_if rsp_if ();
  crb_cfg_if cfg_if ();

  clipped_rect_blit_engine_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  always #5ns clk_i = ~clk_i;

  // one row of the directed table: either a register write or a request,
  // with an optional hand-written response
  typedef struct {
    bit                is_cfg;
    cfg_idx_e          reg_sel;
    logic [SIDE_W-1:0] reg_val;
    req_t              stim;
    bit                typed;
    rsp_t              want;
  } step_t;

  // bitmap sizes as the engine holds them (values above MAX_SIDE are held there)
  int unsigned map_size [4] = '{128, 128, 128, 128};

  // raster state of the running rectangle
  bit                busy;
  op_e               run_op;
  logic [PIX_W-1:0]  run_color;
  int                span_c, span_r, col_n;
  logic [SIDE_W-1:0] row_n;
  logic [ADDR_W-1:0] dst_idx, src_idx;

  rsp_t   owed_rsp [$];   // responses owed by the engine, oldest first
  rsp_t   head_rsp;
  step_t  plan [$];
  int     mismatches;
  int     cycles;
  int     work_done;      // requests other than beats that hit an idle engine
  bit     calm;           // no gaps on either side while set

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // clip the rectangle at (px,py) against a cols x rows bitmap; the partner
  // origin (qx,qy) follows any left or top cut so the two stay aligned
  function automatic bit clip_into(input int cols, input int rows,
                                   inout int px, inout int py,
                                   inout int qx, inout int qy,
                                   inout int w, inout int h);
    if (px + w < 0 || py + h < 0 || px >= cols || py >= rows) return 1'b0;
    if (px < 0) begin
      w += px;
      qx -= px;
      px = 0;
    end
    if (py < 0) begin
      h += py;
      qy -= py;
      py = 0;
    end
    if (px + w > cols) w = cols - px;
    if (py + h > rows) h = rows - py;
    return 1'b1;
  endfunction

  // response to one request, advancing the raster state
  function automatic rsp_t blit_step(req_t r);
    rsp_t             e;
    int               dx, dy, sx, sy, w, h;
    bit               ok;
    bit               fin;
    logic [PIX_W-1:0] pix;
    e = '0;
    if (r.func == FUNC_START) begin
      dx = int'($signed(r.dest_left));
      dy = int'($signed(r.dest_top));
      sx = int'($signed(r.source_left));
      sy = int'($signed(r.source_top));
      w  = int'(r.rect_cols);
      h  = int'(r.rect_rows);
      ok = 1'b1;
      // fill has no source, so only the destination clips it
      if (r.operation == OP_FILL) begin
        sx = 0;
        sy = 0;
      end else begin
        ok = clip_into(int'(map_size[CFG_SOURCE_COLS]), int'(map_size[CFG_SOURCE_ROWS]),
                       sx, sy, dx, dy, w, h);
      end
      if (ok)
        ok = clip_into(int'(map_size[CFG_DEST_COLS]), int'(map_size[CFG_DEST_ROWS]),
                       dx, dy, sx, sy, w, h);
      if (ok && (w <= 0 || h <= 0)) ok = 1'b0;
      // a new start always drops whatever was running
      busy   = ok;
      e.kind = KIND_START;
      if (ok) begin
        run_op    = r.operation;
        run_color = r.fill_color;
        span_c    = w;
        span_r    = h;
        col_n     = 0;
        row_n     = '0;
        dst_idx   = ADDR_W'(dy * int'(map_size[CFG_DEST_COLS]) + dx);
        src_idx   = (run_op == OP_FILL) ? '0
                                        : ADDR_W'(sy * int'(map_size[CFG_SOURCE_COLS]) + sx);
        e.accepted     = 1'b1;
        e.clipped_cols = SIDE_W'(w);
        e.clipped_rows = SIDE_W'(h);
      end
      return e;
    end

    if (!busy) begin
      e.kind = KIND_IDLE_BEAT;
      return e;
    end

    case (run_op)
      OP_FILL:    pix = run_color;
      OP_COPY:    pix = r.source_pixel;
      // transparent source lets the background through
      OP_COMBINE: pix = (r.source_pixel[PIX_W-1:ALPHA_LSB] != '0) ? r.source_pixel
                                                                   : r.backdrop_pixel;
      default:    pix = {r.backdrop_pixel[PIX_W-1:ALPHA_LSB], r.source_pixel[ALPHA_LSB-1:0]};
    endcase
    fin = (col_n + 1 >= span_c) && (int'(row_n) + 1 >= span_r);

    e.kind           = KIND_PIXEL;
    e.dest_address   = dst_idx;
    e.source_address = (run_op == OP_FILL) ? '0 : src_idx;
    e.out_pixel      = pix;
    e.last           = fin;

    col_n++;
    dst_idx++;
    if (run_op != OP_FILL) src_idx++;
    // row wrap uses the strides as they are now, so a size written mid-way counts
    if (col_n >= span_c) begin
      col_n   = 0;
      row_n   = row_n + 1'b1;
      dst_idx = dst_idx + ADDR_W'(map_size[CFG_DEST_COLS]) - ADDR_W'(span_c);
      if (run_op != OP_FILL)
        src_idx = src_idx + ADDR_W'(map_size[CFG_SOURCE_COLS]) - ADDR_W'(span_c);
    end
    if (fin) busy = 1'b0;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // random picks
  // ---------------------------------------------------------------------------

  // idle length for either side: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.func           = func_e'($urandom_range(0, 1));
    r.operation      = op_e'($urandom_range(0, 3));
    r.dest_left      = SIDE_W'($urandom);
    r.dest_top       = SIDE_W'($urandom);
    r.source_left    = SIDE_W'($urandom);
    r.source_top     = SIDE_W'($urandom);
    r.rect_cols      = SIDE_W'($urandom);
    r.rect_rows      = SIDE_W'($urandom);
    r.fill_color     = $urandom;
    r.source_pixel   = $urandom;
    r.backdrop_pixel = $urandom;
    return r;
  endfunction

  // rectangle side: mostly a few pixels so whole rectangles get drawn
  function automatic logic [SIDE_W-1:0] pick_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SIDE_W'($urandom_range(1, 5));
    if (r < 88) return SIDE_W'($urandom_range(0, 16));
    if (r < 97) return SIDE_W'($urandom_range(1, 64));
    return SIDE_W'($urandom);
  endfunction

  // origin around a bitmap of the given extent, a little outside on both ends
  function automatic logic [SIDE_W-1:0] pick_origin(int unsigned extent,
                                                    logic [SIDE_W-1:0] side);
    int lo;
    lo = int'(side) + 3;
    return SIDE_W'(int'($urandom_range(0, extent + lo + 2)) - lo);
  endfunction

  function automatic logic [SIDE_W-1:0] pick_size(bit wild);
    if (wild) begin
      case ($urandom_range(0, 4))
        0:       return '0;
        1:       return SIDE_W'(1);
        2:       return SIDE_W'(MAX_SIDE);
        3:       return '1;
        default: return SIDE_W'($urandom_range(MAX_SIDE + 1, 4095));
      endcase
    end
    if ($urandom_range(0, 3) != 0) return SIDE_W'($urandom_range(1, 20));
    return SIDE_W'($urandom_range(1, MAX_SIDE));
  endfunction

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------

  function automatic step_t base_row();
    step_t s;
    s.is_cfg  = 1'b0;
    s.reg_sel = CFG_DEST_COLS;
    s.reg_val = '0;
    s.stim    = rand_req();
    s.typed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic step_t start_row(op_e op, int dl, int dt, int sl, int st,
                                      int rc, int rr, logic [PIX_W-1:0] color);
    step_t s;
    s = base_row();
    s.stim.func        = FUNC_START;
    s.stim.operation   = op;
    s.stim.dest_left   = SIDE_W'(dl);
    s.stim.dest_top    = SIDE_W'(dt);
    s.stim.source_left = SIDE_W'(sl);
    s.stim.source_top  = SIDE_W'(st);
    s.stim.rect_cols   = SIDE_W'(rc);
    s.stim.rect_rows   = SIDE_W'(rr);
    s.stim.fill_color  = color;
    return s;
  endfunction

  function automatic step_t beat_row(logic [PIX_W-1:0] src, logic [PIX_W-1:0] bg);
    step_t s;
    s = base_row();
    s.stim.func           = FUNC_BEAT;
    s.stim.source_pixel   = src;
    s.stim.backdrop_pixel = bg;
    return s;
  endfunction

  function automatic step_t cfg_row(cfg_idx_e idx, logic [SIDE_W-1:0] val);
    step_t s;
    s = base_row();
    s.is_cfg  = 1'b1;
    s.reg_sel = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t typed_as(step_t s, rsp_t w);
    s.typed = 1'b1;
    s.want  = w;
    return s;
  endfunction

  function automatic rsp_t rep(kind_e k, bit acc, int c, int r);
    rsp_t e;
    e              = '0;
    e.kind         = k;
    e.accepted     = acc;
    e.clipped_cols = SIDE_W'(c);
    e.clipped_rows = SIDE_W'(r);
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers: inputs move on the falling edge, handshakes seen on the rising
  // ---------------------------------------------------------------------------

  // hand one request to the engine; its response is owed from the accepting edge on
  task automatic issue(input req_t r, input bit typed, input rsp_t want, output rsp_t got);
    @(negedge clk_i);
    req_if.valid          <= 1'b1;
    req_if.func           <= r.func;
    req_if.operation      <= r.operation;
    req_if.dest_left      <= r.dest_left;
    req_if.dest_top       <= r.dest_top;
    req_if.source_left    <= r.source_left;
    req_if.source_top     <= r.source_top;
    req_if.rect_cols      <= r.rect_cols;
    req_if.rect_rows      <= r.rect_rows;
    req_if.fill_color     <= r.fill_color;
    req_if.source_pixel   <= r.source_pixel;
    req_if.backdrop_pixel <= r.backdrop_pixel;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    got = blit_step(r);
    if (got.kind != KIND_IDLE_BEAT) work_done++;
    owed_rsp.push_back(typed ? want : got);
  endtask

  task automatic req_gap(input int n);
    if (n > 0) begin
      @(negedge clk_i) req_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // sender holds off until every owed response is back
  task automatic wait_drain();
    @(negedge clk_i) req_if.valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [SIDE_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    map_size[idx] = (val > MAX_SIDE) ? MAX_SIDE : val;
    @(negedge clk_i) cfg_if.valid <= 1'b0;
  endtask

  task automatic send_beat();
    req_t r;
    rsp_t got;
    r = rand_req();
    r.func = FUNC_BEAT;
    // transparent source pixels show up often enough for combine
    if ($urandom_range(0, 3) == 0) r.source_pixel[PIX_W-1:ALPHA_LSB] = '0;
    issue(r, 1'b0, '0, got);
    req_gap(gap_len());
  endtask

  // one phase: new bitmap sizes, then a run of rectangles with their beats
  task automatic run_phase(input bit squeeze);
    cfg_idx_e idx;
    req_t     r;
    rsp_t     got;
    bit       wild;
    int       n_ops, beats, area;
    wait_drain();
    repeat (3) @(posedge clk_i);
    wild = ($urandom_range(0, 7) == 0);
    calm = ($urandom_range(0, 4) == 0);
    idx  = idx.first();
    repeat (4) begin
      if ($urandom_range(0, 3) != 0) cfg_write(idx, pick_size(wild));
      idx = idx.next();
    end
    // a rectangle left unfinished keeps going under the new strides
    if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 6)) send_beat();

    n_ops = $urandom_range(2, 10);
    for (int k = 0; k < n_ops; k++) begin
      r = rand_req();
      // mostly starts aimed at the bitmaps, now and then pure noise
      if ($urandom_range(0, 9) != 0) begin
        r.func        = FUNC_START;
        r.rect_cols   = pick_side();
        r.rect_rows   = pick_side();
        r.dest_left   = pick_origin(map_size[CFG_DEST_COLS], r.rect_cols);
        r.dest_top    = pick_origin(map_size[CFG_DEST_ROWS], r.rect_rows);
        r.source_left = pick_origin(map_size[CFG_SOURCE_COLS], r.rect_cols);
        r.source_top  = pick_origin(map_size[CFG_SOURCE_ROWS], r.rect_rows);
      end
      issue(r, 1'b0, '0, got);
      req_gap(gap_len());

      if (got.kind == KIND_START && got.accepted) begin
        area  = int'(got.clipped_cols) * int'(got.clipped_rows);
        beats = (area <= 96) ? area : $urandom_range(1, 24);
        // sometimes cut it short so the next start lands on a busy engine
        if ($urandom_range(0, 7) == 0) beats = $urandom_range(0, beats - 1);
      end else begin
        beats = $urandom_range(0, 1);
      end
      if ($urandom_range(0, 5) == 0) beats += $urandom_range(1, 2);
      repeat (beats) send_beat();

      if ((squeeze && k == 1) || $urandom_range(0, 19) == 0) wait_drain();
    end
  endtask

  task automatic field_check(input string tag, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, tag, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // response side
  // ---------------------------------------------------------------------------

  // ready toggles in bursts; calm phases keep it high
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i) rsp_if.ready <= 1'b1;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      stall = gap_len();
      if (stall > 0) begin
        @(negedge clk_i) rsp_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // every response is matched with the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (owed_rsp.size() == 0) begin
        mismatches++;
        $display("%0t mismatch response: expected none actual kind %0h", $time, rsp_if.kind);
      end else begin
        head_rsp = owed_rsp.pop_front();
        field_check("kind", 32'(head_rsp.kind), 32'(rsp_if.kind));
        field_check("accepted", 32'(head_rsp.accepted), 32'(rsp_if.accepted));
        field_check("clipped_cols", 32'(head_rsp.clipped_cols), 32'(rsp_if.clipped_cols));
        field_check("clipped_rows", 32'(head_rsp.clipped_rows), 32'(rsp_if.clipped_rows));
        field_check("dest_address", 32'(head_rsp.dest_address), 32'(rsp_if.dest_address));
        field_check("source_address", 32'(head_rsp.source_address),
                    32'(rsp_if.source_address));
        field_check("out_pixel", head_rsp.out_pixel, rsp_if.out_pixel);
        field_check("last", 32'(head_rsp.last), 32'(rsp_if.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d responses outstanding", $time, owed_rsp.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    rsp_t got;
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.func           = FUNC_START;
    req_if.operation      = OP_FILL;
    req_if.dest_left      = '0;
    req_if.dest_top       = '0;
    req_if.source_left    = '0;
    req_if.source_top     = '0;
    req_if.rect_cols      = '0;
    req_if.rect_rows      = '0;
    req_if.fill_color     = '0;
    req_if.source_pixel   = '0;
    req_if.backdrop_pixel = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_DEST_COLS;
    cfg_if.data           = '0;
    calm                  = 1'b0;
    busy                  = 1'b0;

    // beat before any start: ignored
    plan.push_back(typed_as(beat_row(32'h0000_0000, 32'hffff_ffff),
                            rep(KIND_IDLE_BEAT, 1'b0, 0, 0)));
    // 2x2 fill at the origin, second row shows the stride step
    plan.push_back(typed_as(start_row(OP_FILL, 0, 0, -2048, 2047, 2, 2, 32'hffff_ffff),
                            rep(KIND_START, 1'b1, 2, 2)));
    plan.push_back(beat_row(32'hffff_ffff, 32'h0000_0000));
    plan.push_back(beat_row(32'h0000_0000, 32'hffff_ffff));
    plan.push_back(beat_row(32'h8000_0001, 32'h7fff_fffe));
    plan.push_back(beat_row(32'h0000_0000, 32'h0000_0000));
    // wholly right of the destination
    plan.push_back(typed_as(start_row(OP_COPY, 2047, 0, 0, 0, 1, 1, 32'h0),
                            rep(KIND_START, 1'b0, 0, 0)));
    // zero width clips to nothing
    plan.push_back(typed_as(start_row(OP_COPY, 0, 0, 0, 0, 0, 5, 32'h0),
                            rep(KIND_START, 1'b0, 0, 0)));
    // source origin left of and above the source: the destination moves along
    plan.push_back(start_row(OP_COPY, 5, 5, -3, -2, 6, 4, 32'h0));
    plan.push_back(beat_row(32'h1234_5678, 32'hffff_ffff));
    plan.push_back(beat_row(32'hffff_ffff, 32'h0000_0000));
    plan.push_back(beat_row(32'h00ab_cdef, 32'h1111_1111));
    // combine over the bottom right corner, drops the unfinished copy
    plan.push_back(start_row(OP_COMBINE, 126, 127, 0, 0, 4, 4, 32'h0));
    plan.push_back(beat_row(32'h00ff_ffff, 32'haabb_ccdd));
    plan.push_back(beat_row(32'hff00_0000, 32'h00ff_ffff));
    // far up and left of the destination
    plan.push_back(typed_as(start_row(OP_MASK, -2048, -2048, 0, 0, 4095, 4095, 32'h0),
                            rep(KIND_START, 1'b0, 0, 0)));
    plan.push_back(start_row(OP_MASK, 0, 0, 1, 1, 1, 1, 32'h0));
    plan.push_back(beat_row(32'h00ff_ffff, 32'hff00_0000));
    // largest destination, empty source
    plan.push_back(cfg_row(CFG_DEST_COLS, 12'hfff));
    plan.push_back(cfg_row(CFG_DEST_ROWS, 12'(MAX_SIDE)));
    plan.push_back(cfg_row(CFG_SOURCE_COLS, 12'h000));
    plan.push_back(cfg_row(CFG_SOURCE_ROWS, 12'h001));
    plan.push_back(typed_as(start_row(OP_COPY, 0, 0, 0, 0, 1, 1, 32'h0),
                            rep(KIND_START, 1'b0, 0, 0)));
    // last pixel of the destination, top of the address range
    plan.push_back(typed_as(start_row(OP_FILL, 2047, 2047, 0, 0, 4095, 4095, 32'h0),
                            rep(KIND_START, 1'b1, 1, 1)));
    plan.push_back(beat_row(32'hffff_ffff, 32'hffff_ffff));
    plan.push_back(typed_as(start_row(OP_FILL, -2048, -2048, 0, 0, 4095, 4095, 32'h5a5a_a5a5),
                            rep(KIND_START, 1'b1, 2047, 2047)));
    plan.push_back(beat_row(32'h0000_0000, 32'h0000_0000));
    // size written while the big fill is still running; a start then drops it
    plan.push_back(cfg_row(CFG_SOURCE_COLS, 12'h001));
    plan.push_back(typed_as(start_row(OP_COPY, 5, 9, 0, 0, 1, 1, 32'h0),
                            rep(KIND_START, 1'b1, 1, 1)));
    plan.push_back(beat_row(32'hdead_beef, 32'h0000_0000));
    plan.push_back(typed_as(beat_row(32'hffff_ffff, 32'hffff_ffff),
                            rep(KIND_IDLE_BEAT, 1'b0, 0, 0)));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drain();
        repeat (3) @(posedge clk_i);
        cfg_write(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        issue(plan[i].stim, plan[i].typed, plan[i].want, got);
        req_gap(gap_len());
      end
    end

    // first random phase always holds the sender once until everything is back
    run_phase(1'b1);
    while (work_done < WORK_TARGET) run_phase(1'b0);

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (owed_rsp.size() != 0)
      $display("%0t %0d responses never arrived", $time, owed_rsp.size());
    if (mismatches == 0 && owed_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
